// File: hw/rtl/sabs_pkg.sv
package sabs_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned SAMPLE_BITS = 32;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned KEY_W       = SAMPLE_BITS;
  localparam int unsigned SUM_W       = KEY_W + 1;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_QUERY  = 2'd2
  } sabs_kind_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_PAST_END  = 2'd2
  } sabs_status_e;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [KEY_W-1:0] data;
  } sabs_wr_t;

endpackage

// File: hw/rtl/sabs_table.sv
module sabs_table (
  input  logic                         clk_i,
  input  sabs_pkg::sabs_wr_t           wr_i,
  input  logic [sabs_pkg::IDX_W-1:0]   rd_addr_i,
  output logic [sabs_pkg::KEY_W-1:0]   rd_data_o
);
  import sabs_pkg::*;

  logic [KEY_W-1:0] mem_q [TABLE_DEPTH];
  logic [KEY_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hw/rtl/sabs_cmp.sv
module sabs_cmp (
  input  logic [sabs_pkg::SUM_W-1:0] a_i,
  input  logic [sabs_pkg::SUM_W-1:0] c_i,
  input  logic [sabs_pkg::SUM_W-1:0] b_i,
  output logic                       lt_o,
  output logic                       eq_o
);
  import sabs_pkg::*;

  logic [SUM_W-1:0] sum;

  // compare a + c against b, unsigned
  assign sum  = a_i + c_i;
  assign lt_o = (sum < b_i);
  assign eq_o = (sum == b_i);

endmodule

// File: hw/rtl/sorted_axis_bin_search.sv
// Sorted axis table with binary-search queries.
//
// Command channel: drive kind_i and operand_value_i with start high; the item
// is taken at a clock edge where start is high and busy is low. A clear or
// append item updates the table at once and its result appears the next
// cycle with busy still low, so such items may be issued every cycle.
// A query on two or more entries raises busy while a small sequencer runs
// two binary searches (lower and upper bound) over the table, then reads the
// two neighbors of the lower bound for the nearest-sample decision; a query
// on fewer entries does not raise busy and returns all-zero indices. Each
// search step is a read state and then a compare state because the single
// table read port is registered; one compare/add unit is shared by all steps.
// Results come out on done_o for exactly one cycle together with
// status_o and the three indices; the receiver cannot stall, so nothing
// is held back. Reset empties the table (entry count zero) and returns the
// sequencer to idle; table contents are never read beyond the entry count.
module sorted_axis_bin_search (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           kind_i,
  input  logic signed [sabs_pkg::SAMPLE_BITS-1:0] operand_value_i,
  output logic                                 done_o,
  output logic [1:0]                           status_o,
  output logic [sabs_pkg::IDX_W-1:0]           closest_index_o,
  output logic [sabs_pkg::IDX_W-1:0]           lower_index_o,
  output logic signed [sabs_pkg::CNT_W-1:0]    upper_index_o
);
  import sabs_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_LB_RD  = 8'b0000_0010,
    ST_LB_CMP = 8'b0000_0100,
    ST_UB_RD  = 8'b0000_1000,
    ST_UB_CMP = 8'b0001_0000,
    ST_HI_RD  = 8'b0010_0000,
    ST_LO_RD  = 8'b0100_0000,
    ST_NEAR   = 8'b1000_0000
  } state_e;

  localparam logic [KEY_W-1:0] SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(TABLE_DEPTH);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [CNT_W-1:0] lb_q, lb_d;
  logic [IDX_W-1:0] near_q, near_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [KEY_W-1:0] after_q, after_d;

  logic                    done_q, done_d;
  sabs_status_e            status_q, status_d;
  logic [IDX_W-1:0]        closest_q, closest_d;
  logic [IDX_W-1:0]        lower_q, lower_d;
  logic [CNT_W-1:0]        upper_q, upper_d;

  sabs_wr_t         wr;
  logic [IDX_W-1:0] rd_addr;
  logic [KEY_W-1:0] rd_data;

  logic [SUM_W-1:0] cmp_a, cmp_c, cmp_b;
  logic             cmp_lt, cmp_eq;
  logic [CNT_W-1:0] mid_calc;
  logic [CNT_W-1:0] hi_sel;

  sabs_table u_table (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  sabs_cmp u_cmp (
    .a_i  (cmp_a),
    .c_i  (cmp_c),
    .b_i  (cmp_b),
    .lt_o (cmp_lt),
    .eq_o (cmp_eq)
  );

  assign mid_calc = lo_q + ((hi_q - lo_q) >> 1);

  // Clamp the lower bound inward to pick the neighbor pair.
  always_comb begin
    hi_sel = lb_q;
    if (hi_sel == count_q) begin
      hi_sel = count_q - CNT_W'(1);
    end
    if (hi_sel == '0) begin
      hi_sel = CNT_W'(1);
    end
  end

  always_comb begin
    // shared compare unit: search steps test sample against key,
    // the nearest step tests after + before against twice the key
    cmp_a = {1'b0, rd_data};
    cmp_c = '0;
    cmp_b = {1'b0, key_q};
    if (state_q == ST_NEAR) begin
      cmp_a = {1'b0, after_q};
      cmp_c = {1'b0, rd_data};
      cmp_b = {key_q, 1'b0};
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    lb_d      = lb_q;
    near_d    = near_q;
    key_d     = key_q;
    after_d   = after_q;
    done_d    = 1'b0;
    status_d  = status_q;
    closest_d = closest_q;
    lower_d   = lower_q;
    upper_d   = upper_q;
    wr.en     = 1'b0;
    wr.addr   = count_q[IDX_W-1:0];
    wr.data   = operand_value_i ^ SIGN_FLIP;
    rd_addr   = mid_q[IDX_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          status_d  = STATUS_OK;
          closest_d = '0;
          lower_d   = '0;
          upper_d   = '0;
          case (kind_i)
            KIND_CLEAR: begin
              count_d = '0;
              done_d  = 1'b1;
            end
            KIND_APPEND: begin
              if (count_q < DEPTH_C) begin
                wr.en   = 1'b1;
                count_d = count_q + CNT_W'(1);
              end else begin
                status_d = STATUS_FULL;
              end
              done_d = 1'b1;
            end
            KIND_QUERY: begin
              if (count_q >= CNT_W'(2)) begin
                key_d   = operand_value_i ^ SIGN_FLIP;
                lo_d    = '0;
                hi_d    = count_q;
                state_d = ST_LB_RD;
              end else begin
                done_d = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      ST_LB_RD: begin
        if (lo_q < hi_q) begin
          rd_addr = mid_calc[IDX_W-1:0];
          mid_d   = mid_calc;
          state_d = ST_LB_CMP;
        end else begin
          lb_d    = lo_q;
          lo_d    = '0;
          hi_d    = count_q;
          state_d = ST_UB_RD;
        end
      end

      ST_LB_CMP: begin
        // go right while sample < key
        if (cmp_lt) begin
          lo_d = mid_q + CNT_W'(1);
        end else begin
          hi_d = mid_q;
        end
        state_d = ST_LB_RD;
      end

      ST_UB_RD: begin
        if (lo_q < hi_q) begin
          rd_addr = mid_calc[IDX_W-1:0];
          mid_d   = mid_calc;
          state_d = ST_UB_CMP;
        end else begin
          upper_d = lo_q - CNT_W'(1);
          if (lb_q == count_q) begin
            status_d = STATUS_PAST_END;
            lower_d  = '0;
          end else begin
            lower_d = lb_q[IDX_W-1:0];
          end
          near_d  = hi_sel[IDX_W-1:0];
          state_d = ST_HI_RD;
        end
      end

      ST_UB_CMP: begin
        // go right while sample <= key
        if (cmp_lt || cmp_eq) begin
          lo_d = mid_q + CNT_W'(1);
        end else begin
          hi_d = mid_q;
        end
        state_d = ST_UB_RD;
      end

      ST_HI_RD: begin
        rd_addr = near_q;
        state_d = ST_LO_RD;
      end

      ST_LO_RD: begin
        rd_addr = near_q - IDX_W'(1);
        after_d = rd_data;
        state_d = ST_NEAR;
      end

      ST_NEAR: begin
        // after is nearer when after + before < 2 * key
        if (cmp_lt) begin
          closest_d = near_q;
        end else begin
          closest_d = near_q - IDX_W'(1);
        end
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    lb_q      <= lb_d;
    near_q    <= near_d;
    key_q     <= key_d;
    after_q   <= after_d;
    status_q  <= status_d;
    closest_q <= closest_d;
    lower_q   <= lower_d;
    upper_q   <= upper_d;
  end

  assign busy            = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign closest_index_o = closest_q;
  assign lower_index_o   = lower_q;
  assign upper_index_o   = upper_q;

endmodule

// File: test/sorted_axis_bin_search_tb.sv
`timescale 1ns / 100ps

module sorted_axis_bin_search_tb;
  import sabs_pkg::*;

  // Kind code that the block decodes to nothing; its result is all zero.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam longint SMP_MIN = -64'sd2147483648;
  localparam longint SMP_MAX = 64'sd2147483647;

  // One result of the block, as the ports carry it.
  typedef struct packed {
    logic [1:0]              status;
    logic [IDX_W-1:0]        closest;
    logic [IDX_W-1:0]        lower;
    logic signed [CNT_W-1:0] upper;
  } bounds_t;

  // Shadow copy of the axis table plus the queue of search results still due.
  class axis_lookup_sb;
    logic signed [SAMPLE_BITS-1:0] sample_mem [TABLE_DEPTH];
    int unsigned                   filled;
    bounds_t                       bounds_due [$];
    int                            errors;

    function new();
      filled = 0;
      errors = 0;
    endfunction

    // Halve [lo,hi) exactly as the hardware does, so unsorted tables agree too.
    // Find the first sample >= v, or the first sample > v when past_equal is set.
    function int unsigned first_index_past(logic signed [SAMPLE_BITS-1:0] v,
                                           bit past_equal);
      int unsigned lo, hi, mid;
      bit go_right;
      lo = 0;
      hi = filled;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        go_right = past_equal ? (sample_mem[mid] <= v) : (sample_mem[mid] < v);
        if (go_right) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    function void note_item(logic [1:0] kind, logic signed [SAMPLE_BITS-1:0] value);
      bounds_t     r;
      int unsigned lb, ub, nb;
      r = '0;
      case (kind)
        KIND_CLEAR: filled = 0;
        KIND_APPEND: begin
          if (filled < TABLE_DEPTH) begin
            sample_mem[filled] = value;
            filled++;
          end else begin
            r.status = STATUS_FULL;
          end
        end
        KIND_QUERY: begin
          if (filled >= 2) begin
            lb = first_index_past(value, 1'b0);
            ub = first_index_past(value, 1'b1);
            // Clamp the upper neighbor inward so both neighbors exist.
            nb = lb;
            if (nb == filled) nb = filled - 1;
            if (nb == 0) nb = 1;
            // Upper neighbor wins only when strictly nearer: a + b < 2v.
            if (longint'(sample_mem[nb]) + longint'(sample_mem[nb - 1])
                < 2 * longint'(value))
              r.closest = IDX_W'(nb);
            else
              r.closest = IDX_W'(nb - 1);
            if (lb == filled) r.status = STATUS_PAST_END;
            else r.lower = IDX_W'(lb);
            r.upper = CNT_W'(ub - 1);
          end
        end
        default: ;
      endcase
      bounds_due = {bounds_due, r};
    endfunction

    function void check_result(bounds_t got);
      bounds_t want;
      if (bounds_due.size() == 0) begin
        $display("%t: unexpected result status %0d closest %0d lower %0d upper %0d",
                 $realtime, got.status, got.closest, got.lower, got.upper);
        errors++;
        return;
      end
      want = bounds_due.pop_front();
      if (got !== want) begin
        $display("%t: mismatch expected status %0d closest %0d lower %0d upper %0d",
                 $realtime, want.status, want.closest, want.lower, want.upper);
        $display("%t:          actual   status %0d closest %0d lower %0d upper %0d",
                 $realtime, got.status, got.closest, got.lower, got.upper);
        errors++;
      end
    endfunction

    function int pending();
      return bounds_due.size();
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  logic [1:0]                    kind_i;
  logic signed [SAMPLE_BITS-1:0] operand_value_i;
  logic                          done_o;
  logic [1:0]                    status_o;
  logic [IDX_W-1:0]              closest_index_o;
  logic [IDX_W-1:0]              lower_index_o;
  logic signed [CNT_W-1:0]       upper_index_o;

  axis_lookup_sb sb;
  int            idle_pct;
  int            items_sent;
  int            drain_wait;

  sorted_axis_bin_search DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .operand_value_i (operand_value_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .closest_index_o (closest_index_o),
    .lower_index_o   (lower_index_o),
    .upper_index_o   (upper_index_o)
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Results are strobed for one cycle and cannot be held off: grab every one.
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result({status_o, closest_index_o, lower_index_o, upper_index_o});
  end

  // Saturate a wide value into the signed sample range.
  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(longint v);
    if (v < SMP_MIN) return SAMPLE_BITS'(SMP_MIN);
    if (v > SMP_MAX) return SAMPLE_BITS'(SMP_MAX);
    return SAMPLE_BITS'(v);
  endfunction

  // Bias random operands toward the extremes and around zero.
  function automatic logic signed [SAMPLE_BITS-1:0] rand_value();
    case ($urandom_range(9))
      0: return SAMPLE_BITS'(SMP_MIN);
      1: return SAMPLE_BITS'(SMP_MAX);
      2: return '0;
      3, 4: return sat_sample(longint'($urandom_range(200)) - 100);
      default: return $signed($urandom);
    endcase
  endfunction

  // Aim a query at the interesting spots of the current table: hits, near misses,
  // midpoints (ties when the gap is even), and both ends.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_query(ref int pts[$]);
    int unsigned idx;
    if (pts.size() == 0) return rand_value();
    idx = $urandom_range(pts.size() - 1);
    case ($urandom_range(7))
      0: return pts[idx];
      1: return sat_sample(longint'(pts[idx]) + 1);
      2: return sat_sample(longint'(pts[idx]) - 1);
      3: begin
        if (idx + 1 < pts.size())
          return sat_sample((longint'(pts[idx]) + longint'(pts[idx + 1])) >>> 1);
        return pts[idx];
      end
      4: return sat_sample(longint'(pts[0]) - $urandom_range(1, 5));
      5: return sat_sample(longint'(pts[pts.size() - 1]) + $urandom_range(1, 5));
      default: return rand_value();
    endcase
  endfunction

  // Present one item and hold it until the block takes it. Inputs move only on
  // the falling edge; the task returns on the falling edge after acceptance.
  task automatic send_item(logic [1:0] kind, logic signed [SAMPLE_BITS-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start           = 1'b1;
    kind_i          = kind;
    operand_value_i = value;
    do @(posedge clk_i); while (busy);
    sb.note_item(kind, value);
    if (kind != KIND_UNUSED) items_sent++;
    @(negedge clk_i);
  endtask

  // Drop a stray item into a sequence now and then: any kind, any operand.
  task automatic maybe_noise();
    if ($urandom_range(11) == 0)
      send_item(2'($urandom_range(3)), rand_value());
  endtask

  // Clear, load an ascending table, then query it. Narrow tables give
  // duplicates and exact ties; wide ones spread over the whole range.
  task automatic run_episode(int unsigned max_fill);
    int          pts[$];
    int unsigned fill, n_q;
    longint      base;
    bit          narrow;
    fill   = $urandom_range(max_fill);
    n_q    = $urandom_range(1, 10);
    narrow = $urandom_range(1);
    case ($urandom_range(3))
      0: base = SMP_MIN;
      1: base = SMP_MAX - 80;
      2: base = longint'($urandom_range(400)) - 200;
      default: base = longint'($signed($urandom));
    endcase
    if (base > SMP_MAX - 80) base = SMP_MAX - 80;
    for (int unsigned i = 0; i < fill; i++) begin
      if (narrow) pts = {pts, int'(base + 2 * $urandom_range(40))};
      else pts = {pts, int'($signed($urandom))};
    end
    pts.sort();
    send_item(KIND_CLEAR, rand_value());
    foreach (pts[i]) begin
      maybe_noise();
      send_item(KIND_APPEND, pts[i]);
    end
    for (int unsigned q = 0; q < n_q; q++) begin
      maybe_noise();
      send_item(KIND_QUERY, pick_query(pts));
    end
  endtask

  initial begin
    sb              = new();
    idle_pct        = 32;
    items_sent      = 0;
    drain_wait      = 0;
    rst_ni          = 1'b0;
    start           = 1'b0;
    kind_i          = KIND_CLEAR;
    operand_value_i = '0;
    // Hold reset, then release it on a falling edge.
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty and one-entry tables answer zero.
    send_item(KIND_QUERY, 32'sd5);
    send_item(KIND_APPEND, SAMPLE_BITS'(SMP_MIN));
    send_item(KIND_QUERY, SAMPLE_BITS'(SMP_MIN));
    // Table {MIN, 0, 0, MAX}: extremes, a duplicate pair and an exact tie.
    send_item(KIND_APPEND, '0);
    send_item(KIND_APPEND, '0);
    send_item(KIND_APPEND, SAMPLE_BITS'(SMP_MAX));
    send_item(KIND_QUERY, SAMPLE_BITS'(SMP_MIN));
    send_item(KIND_QUERY, SAMPLE_BITS'(SMP_MAX));
    send_item(KIND_QUERY, '0);
    send_item(KIND_QUERY, -32'sd1);
    send_item(KIND_QUERY, -32'sd1073741824);
    send_item(KIND_QUERY, 32'sd2147483646);
    // Unused kind leaves the table alone.
    send_item(KIND_UNUSED, 32'sd77);
    send_item(KIND_QUERY, 32'sd1);
    // Table {-10, 4}: below the first sample, a tie, past the end, last hit.
    send_item(KIND_CLEAR, -32'sd1);
    send_item(KIND_APPEND, -32'sd10);
    send_item(KIND_APPEND, 32'sd4);
    send_item(KIND_QUERY, SAMPLE_BITS'(SMP_MIN));
    send_item(KIND_QUERY, -32'sd3);
    send_item(KIND_QUERY, 32'sd100);
    send_item(KIND_QUERY, 32'sd4);
    send_item(KIND_UNUSED, -32'sd1);

    // Random: sender gaps of 32 in 100, then 83 in 100, then none.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 32 : (phase == 1) ? 83 : 0;
      for (int target = items_sent + 135; items_sent < target; )
        run_episode(($urandom_range(9) == 0) ? 120 : 16);
    end
    start = 1'b0;

    // Drain outstanding results, then allow a full query's latency for strays.
    while (sb.pending() != 0 && drain_wait < 20000) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (64) @(posedge clk_i);
    if (sb.pending() != 0)
      $display("%t: %0d results never arrived", $realtime, sb.pending());

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
